@@ rtl/date_to_day_counts_and_weekday_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef DATE_TO_DAY_COUNTS_AND_WEEKDAY_MACROS_SVH
`define DATE_TO_DAY_COUNTS_AND_WEEKDAY_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define DTDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtdc: same-cycle check failed");

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define DTDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtdc: next-cycle check failed");

`endif

@@ rtl/dtdc_pkg.sv @@
package dtdc_pkg;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIM_W   = 5;
  localparam int ORD_W   = 9;
  localparam int CDAY_W  = 16;
  localparam int ADAY_W  = 22;
  localparam int WD_W    = 3;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // Internal widths.
  localparam int WYEAR_W  = 15;   // year + 400, up to 16783
  localparam int SUM_W    = 16;   // weekday congruence sum
  localparam int PROD_W   = 26;   // quarter year times reciprocal of 25
  localparam int HUND_W   = 9;    // year / 100
  localparam int PTERM_W  = 13;   // leap-day count before the year, plus one
  localparam int REC_SH   = 17;   // reciprocal scaling shift
  localparam int PROD7_W  = 31;   // sum times reciprocal of 7
  localparam int Q7_W     = 14;
  localparam int CENT_N_W = 7;

  // Reciprocals scaled by 2^17; exact over the value ranges used here.
  localparam logic [12:0] RECIP_25 = 13'd5243;
  localparam logic [14:0] RECIP_7  = 15'd18725;

  localparam logic [YEAR_W-1:0] CENTURY_BASE = 14'd2000;
  localparam logic [YEAR_W-1:0] CENTURY_END  = 14'd2100;

  // Days before month k+1 in a common year.
  localparam logic [ORD_W-1:0] DAYS_BEFORE [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // floor(3 * (m + 1) / 5) for the shifted month m.
  localparam logic [3:0] WM_TERM [16] = '{
    4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9, 4'd9
  };

  // First stage: date, shifted weekday date and the three reciprocal products.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] wmonth;
    logic [WYEAR_W-1:0] wyear;
    logic [PROD_W-1:0]  prod_y;
    logic [PROD_W-1:0]  prod_p;
    logic [PROD_W-1:0]  prod_w;
  } stage_a_t;

  // Second stage: month values, century count, weekday sum and the partial absolute count.
  typedef struct packed {
    logic [DIM_W-1:0]   dim;
    logic [ORD_W-1:0]   ord;
    logic [CDAY_W-1:0]  cday;
    logic               cvalid;
    logic [ADAY_W-1:0]  yr365;
    logic [PTERM_W-1:0] pterm;
    logic [SUM_W-1:0]   wsum;
  } stage_b_t;

  // Third and last stages: finished counts.
  typedef struct packed {
    logic [DIM_W-1:0]  dim;
    logic [ORD_W-1:0]  ord;
    logic [CDAY_W-1:0] cday;
    logic              cvalid;
    logic [ADAY_W-1:0] aday;
  } stage_c_t;

  // Days of the months before month m, clamped to the twelve of the year.
  function automatic logic [ORD_W-1:0] earlier_months(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
    logic [MONTH_W-1:0] n;
    n = (m == 4'd0) ? 4'd0 : m - 4'd1;
    if (n > 4'd12) begin
      n = 4'd12;
    end
    return DAYS_BEFORE[n] + ((leap && (n >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

  // Month length; any month code that is not a real month gets February's.
  function automatic logic [DIM_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DIM_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = leap ? 5'd29 : 5'd28;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/date_to_day_counts_and_weekday.sv @@
// Channel | Direction | Beat contents
// in_     | sink      | tdata: year_value, month_value, day_value
// out_    | source    | tdata: days_in_month, ordinal_day, century_day, absolute_day,
//         |           |        weekday; tuser: century_valid
//
// Four register stages, A, B, C and D; stage D is the output register.
// A new date is accepted every cycle while the output side keeps taking beats.
// The whole pipeline holds when a result sits in the output register unclaimed.
// The stage valid bits clear on a synchronous, active-low reset.
module date_to_day_counts_and_weekday
  import dtdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [13:0] year_value, [17:14] month_value, [22:18] day_value, [23] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [4:0] days_in_month, [13:5] ordinal_day, [29:14] century_day,
  // [51:30] absolute_day, [54:52] weekday, [55] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] century_valid
  output logic                  out_tuser
);

  logic     en;
  logic     v_a_r, v_b_r, v_c_r, v_d_r;
  stage_a_t a_r, a_nxt;
  stage_b_t b_r, b_nxt;
  stage_c_t c_r, c_nxt;
  stage_c_t d_r;
  logic [WD_W-1:0] weekday;

  // The pipeline moves whenever the output register is free or being drained.
  assign en        = !v_d_r || out_tready;
  assign in_tready = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_tvalid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  // Stage A: unpack, shift early months to the year before for the weekday,
  // and start the divisions by 100.
  always_comb begin
    logic [YEAR_W-1:0] pyear;
    a_nxt.year  = in_tdata[13:0];
    a_nxt.month = in_tdata[17:14];
    a_nxt.day   = in_tdata[22:18];
    pyear       = a_nxt.year - 14'd1;
    if (a_nxt.month < 4'd3) begin
      a_nxt.wmonth = a_nxt.month + 4'd12;
      a_nxt.wyear  = WYEAR_W'(a_nxt.year) + 15'd399;
    end else begin
      a_nxt.wmonth = a_nxt.month;
      a_nxt.wyear  = WYEAR_W'(a_nxt.year) + 15'd400;
    end
    a_nxt.prod_y = PROD_W'(a_nxt.year[YEAR_W-1:2]) * PROD_W'(RECIP_25);
    a_nxt.prod_p = PROD_W'(pyear[YEAR_W-1:2]) * PROD_W'(RECIP_25);
    a_nxt.prod_w = PROD_W'(a_nxt.wyear[WYEAR_W-1:2]) * PROD_W'(RECIP_25);
  end

  // Stage B: leap rule, month values, century count, weekday sum and the
  // pieces of the absolute count.
  always_comb begin
    logic [HUND_W-1:0]   hy, hp, hw;
    logic [CDAY_W-1:0]   h100;
    logic                leap;
    logic [YEAR_W-1:0]   pyear;
    logic [CENT_N_W-1:0] cn;
    logic [CENT_N_W-1:0] cn3;
    logic [22:0]         yr_full;
    hy    = a_r.prod_y[PROD_W-1:REC_SH];
    hp    = a_r.prod_p[PROD_W-1:REC_SH];
    hw    = a_r.prod_w[PROD_W-1:REC_SH];
    h100  = CDAY_W'(hy) * 16'd100;
    leap  = (a_r.year[1:0] == 2'b00) &&
            ((h100 != CDAY_W'(a_r.year)) || (hy[1:0] == 2'b00));
    pyear = a_r.year - 14'd1;

    b_nxt.dim = month_len(a_r.month, leap);
    b_nxt.ord = earlier_months(a_r.month, leap) + ORD_W'(a_r.day);

    // Century count uses the plain divide-by-4 rule.
    cn  = CENT_N_W'(a_r.year - CENTURY_BASE);
    cn3 = cn + 7'd3;
    b_nxt.cvalid = (a_r.year >= CENTURY_BASE) && (a_r.year < CENTURY_END);
    if (b_nxt.cvalid) begin
      b_nxt.cday = CDAY_W'(cn) * 16'd365 + CDAY_W'(cn3[CENT_N_W-1:2])
                 + CDAY_W'(earlier_months(a_r.month, cn[1:0] == 2'b00))
                 + CDAY_W'(a_r.day);
    end else begin
      b_nxt.cday = '0;
    end

    // Days before the year; year zero has none.
    yr_full     = 23'(a_r.year) * 23'd365;
    b_nxt.yr365 = yr_full[ADAY_W-1:0];
    if (a_r.year != '0) begin
      b_nxt.pterm = PTERM_W'(pyear[YEAR_W-1:2]) - PTERM_W'(hp)
                  + PTERM_W'(hp[HUND_W-1:2]) + 13'd1;
    end else begin
      b_nxt.yr365 = '0;
      b_nxt.pterm = '0;
    end

    // Weekday congruence sum.
    b_nxt.wsum = SUM_W'(a_r.day) + SUM_W'({a_r.wmonth, 1'b0})
               + SUM_W'(WM_TERM[a_r.wmonth]) + SUM_W'(a_r.wyear)
               + SUM_W'(a_r.wyear[WYEAR_W-1:2]) - SUM_W'(hw)
               + SUM_W'(hw[HUND_W-1:2]) + 16'd1;
  end

  // Stage C: finish the absolute count.
  always_comb begin
    c_nxt.dim    = b_r.dim;
    c_nxt.ord    = b_r.ord;
    c_nxt.cday   = b_r.cday;
    c_nxt.cvalid = b_r.cvalid;
    c_nxt.aday   = b_r.yr365 + ADAY_W'(b_r.pterm) + ADAY_W'(b_r.ord);
  end

  // Payload stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= c_r;
    end
  end

  // Weekday remainder runs alongside stages C and D.
  dtdc_mod7 u_mod7 (
    .clk     (clk),
    .en      (en),
    .wsum    (b_r.wsum),
    .weekday (weekday)
  );

  // Output register drives the result channel.
  assign out_tvalid = v_d_r;
  assign out_tdata  = {1'b0, weekday, d_r.aday, d_r.cday, d_r.ord, d_r.dim};
  assign out_tuser  = d_r.cvalid;

endmodule

@@ rtl/dtdc_mod7.sv @@
module dtdc_mod7
  import dtdc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] wsum,
  output logic [WD_W-1:0]  weekday
);

  logic [PROD7_W-1:0] prod_r;
  logic [SUM_W-1:0]   sum_r;
  logic [WD_W-1:0]    wd_r;
  logic [WD_W-1:0]    wd_nxt;
  logic [Q7_W-1:0]    quot;
  logic [SUM_W-1:0]   rem_full;
  logic [WD_W-1:0]    rem;

  // Quotient by 7 through the scaled reciprocal, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD7_W'(wsum) * PROD7_W'(RECIP_7);
      sum_r  <= wsum;
    end
  end

  // Remainder, then rotate so that Monday is zero.
  always_comb begin
    quot     = prod_r[PROD7_W-1:REC_SH];
    rem_full = sum_r - SUM_W'(quot) * SUM_W'(7);
    rem      = rem_full[WD_W-1:0];
    wd_nxt   = (rem == 3'd0) ? 3'd6 : rem - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wd_r <= wd_nxt;
    end
  end

  assign weekday = wd_r;

endmodule

@@ rtl/dtdc_checker.sv @@
`include "date_to_day_counts_and_weekday_macros.svh"

module dtdc_checker
  import dtdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A stalled result beat stays put.
  `DTDC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Month length is always one of the four real lengths.
  `DTDC_ASSERT_IMP(a_dim_range, out_tvalid, (out_tdata[4:0] >= 5'd28) && (out_tdata[4:0] <= 5'd31))

  // The century count is zero whenever its flag is clear.
  `DTDC_ASSERT_IMP(a_cday_zero, out_tvalid && !out_tuser, out_tdata[29:14] == 16'd0)

  // The weekday remainder never reaches seven.
  `DTDC_ASSERT_IMP(a_wd_range, out_tvalid, out_tdata[54:52] <= 3'd6)

endmodule

bind date_to_day_counts_and_weekday dtdc_checker u_dtdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
